FILE: rtl/core/olii_pkg.sv
// Shared types and codes for the ordered list with indexed insert.
package olii_pkg;

	localparam int IDX_W  = 8;
	localparam int DATA_W = 32;
	localparam int CNT_OUT_W = 6;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [CNT_OUT_W-1:0]     count;
		logic signed [DATA_W-1:0] read_data;
		logic                     error_seen;
	} rsp_t;

	// Per-cycle control broadcast to every cell of the chain.
	typedef struct packed {
		logic             ins;
		logic             app;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] cnt;
	} cell_ctl_t;

endpackage

FILE: rtl/core/olii_cell.sv
// One storage cell of the list chain: holds the entry at a fixed position.
module olii_cell import olii_pkg::*; #(
	parameter int POS        = 0,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [VALUE_BITS-1:0] prev,
	input  logic [VALUE_BITS-1:0] wdata,
	output logic [VALUE_BITS-1:0] entry
);

	localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

	logic [VALUE_BITS-1:0] entry_q;

	// Insert: take the neighbour below when above the slot, zero at the slot; append: load wdata at the fill position.
	always_ff @(posedge clk) begin
		if (ctl.ins && (MY_POS > ctl.idx)) begin
			entry_q <= prev;
		end else if (ctl.ins && (MY_POS == ctl.idx)) begin
			entry_q <= '0;
		end else if (ctl.app && (MY_POS == ctl.cnt)) begin
			entry_q <= wdata;
		end
	end

	assign entry = entry_q;

endmodule

FILE: rtl/core/ordered_list_with_indexed_insert_top.sv
// Top level of the ordered list with indexed insert: command decode, cell chain, response register.
//
//  Channel | Direction | Handshake            | Payload
//  cmd     | in        | cmd_valid / cmd_ready | cmd (cmd_t): action, value, index
//  rsp     | out       | rsp_valid / rsp_ready | rsp (rsp_t): status, count, read_data, error_seen
//
// For every accepted command, the cells of the chain compare their own
// position with the index and shift or load in parallel, and the response is
// registered at the same edge. One command per cycle is sustained while rsp
// is taken. A stalled response holds the command channel until it leaves the
// output register. Reset clears the fill count, the error flag and the
// response valid; list entries are undefined until written.
module ordered_list_with_indexed_insert_top import olii_pkg::*; #(
	parameter int CAPACITY   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int RD_W  = $clog2(CAPACITY);

	logic [CNT_W-1:0] cnt_q;
	logic             err_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [VALUE_BITS-1:0] entries [CAPACITY];
	logic [VALUE_BITS-1:0] wdata;
	logic signed [63:0]    value_ext;
	logic signed [63:0]    rd_ext;
	logic [IDX_W-1:0]      cnt_ext;
	logic                  accept;
	logic                  full;
	logic                  rd_ok;
	logic                  do_app;
	logic                  do_ins;
	logic                  set_err;
	logic [1:0]            status;
	cell_ctl_t             ctl;

	// Accept while the output register is empty or being emptied.
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign accept    = cmd_valid && cmd_ready;

	assign cnt_ext = IDX_W'(cnt_q);
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign rd_ok   = (cmd.index < cnt_ext);

	// Keep the low bits of the sign-extended value.
	assign value_ext = 64'(cmd.value);
	assign wdata     = value_ext[VALUE_BITS-1:0];

	// Decode the command against the current length and the sticky flag.
	always_comb begin
		do_app  = 1'b0;
		do_ins  = 1'b0;
		set_err = 1'b0;
		status  = ST_OK;
		case (cmd.action)
			ACT_APPEND: begin
				if (err_q) begin
					status = ST_IGNORED;
				end else if (full) begin
					status  = ST_FULL;
					set_err = 1'b1;
				end else begin
					do_app = 1'b1;
				end
			end
			ACT_INSERT: begin
				if (err_q) begin
					status = ST_IGNORED;
				end else if (cmd.index > cnt_ext) begin
					status  = ST_RANGE;
					set_err = 1'b1;
				end else if (full) begin
					status  = ST_FULL;
					set_err = 1'b1;
				end else begin
					do_ins = 1'b1;
				end
			end
			ACT_READ: begin
				if (!rd_ok) begin
					status = ST_RANGE;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign ctl.ins = accept && do_ins;
	assign ctl.app = accept && do_app;
	assign ctl.idx = cmd.index;
	assign ctl.cnt = cnt_ext;

	// Chain of cells: on an insert, each cell above the slot takes its lower neighbour.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		if (k == 0) begin : g_first
			olii_cell #(.POS(k), .VALUE_BITS(VALUE_BITS)) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.prev  ('0),
				.wdata (wdata),
				.entry (entries[k])
			);
		end else begin : g_rest
			olii_cell #(.POS(k), .VALUE_BITS(VALUE_BITS)) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.prev  (entries[k-1]),
				.wdata (wdata),
				.entry (entries[k])
			);
		end
	end

	// Read port: sign-extend the stored value from its storage width.
	assign rd_ext = 64'($signed(entries[cmd.index[RD_W-1:0]]));

	// Advance length and flag on accepted commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (do_app || do_ins) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (set_err) begin
				err_q <= 1'b1;
			end
		end
	end

	// Hold the response until taken; load a new one on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status     <= status;
			rsp_q.count      <= CNT_OUT_W'(cnt_q + CNT_W'(do_app || do_ins));
			rsp_q.read_data  <= (cmd.action == ACT_READ && rd_ok) ? rd_ext[DATA_W-1:0] : '0;
			rsp_q.error_seen <= err_q || set_err;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Length never exceeds the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	// The error flag is sticky.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(err_q))
		else $error("error flag cleared");

	// Once failed, appends and inserts leave the length alone.
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_q && (cmd.action == ACT_APPEND || cmd.action == ACT_INSERT))
		|=> $stable(cnt_q))
		else $error("length changed after error");

	// The reported count matches the new length.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rsp.count == CNT_OUT_W'(cnt_q)))
		else $error("response count mismatch");

endmodule
